// File: design/plas_pkg.sv
// Shared types and constants for the periodic LED / ADC scheduler.
// Used by plas_ctrl, plas_dp and periodic_led_adc_scheduler; no dependencies.
`default_nettype none

package plas_pkg;

  // Morse table depth and the widths that follow from it
  localparam int SEQ_DEPTH = 256;
  localparam int SEQ_AW    = $clog2(SEQ_DEPTH);

  localparam int TICK_W  = 32;
  localparam int TICK_IW = $clog2(TICK_W);
  localparam int PER_W   = 16;
  localparam int DIT_W   = 16;
  localparam int DITS_W  = 8;
  localparam int POS_W   = 8;
  localparam int LEN_W   = 9;
  localparam int MODE_W  = 3;

  localparam logic [DIT_W-1:0] DIT_RESET = 16'd500;

  // Request codes
  localparam logic [MODE_W-1:0] MODE_TICK    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ADC_OFF = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ADC_PER = 3'd2;
  localparam logic [MODE_W-1:0] MODE_LED_OFF = 3'd3;
  localparam logic [MODE_W-1:0] MODE_BLINK   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_MORSE   = 3'd5;
  localparam logic [MODE_W-1:0] MODE_LOAD    = 3'd6;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [PER_W-1:0]  period;
    logic [PER_W-1:0]  offset;
    logic              off_level;
    logic [LEN_W-1:0]  morse_length;
    logic [7:0]        entry_index;
    logic [DITS_W-1:0] entry_dits;
  } plas_in_t;

  typedef struct packed {
    logic led_level;
    logic led_changed;
    logic adc_fire;
    logic led_active;
    logic morse_active;
    logic rejected;
  } plas_out_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic tick_step;
    logic led_advance;
    logic adc_off;
    logic led_off;
    logic set_rej;
    logic morse_start;
    logic tbl_write;
    logic div_start;
    logic div_step;
    logic align;
    logic tbl_read;
    logic morse_step;
    logic out_load;
  } plas_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              period_zero;
    logic              length_zero;
    logic              led_hit;
    logic              morse_run;
    logic              div_last;
    logic              out_busy;
  } plas_sts_t;

endpackage

`default_nettype wire

// File: design/plas_ctrl.sv
// Sequencing state machine for the scheduler: decodes each request and steps
// the datapath through tick, alignment divide and Morse table phases. Uses plas_pkg.
`default_nettype none

module plas_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  plas_pkg::plas_sts_t sts,
  output plas_pkg::plas_cmd_t cmd
);
  import plas_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DECODE = 8'b0000_0010,
    S_DIV    = 8'b0000_0100,
    S_ALIGN  = 8'b0000_1000,
    S_MEMRD  = 8'b0001_0000,
    S_MUL    = 8'b0010_0000,
    S_LEDADV = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } plas_state_t;

  plas_state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_FINISH;
        case (sts.mode)
          MODE_TICK: begin
            cmd.tick_step = 1'b1;
            if (sts.led_hit && sts.morse_run) begin
              state_nxt = S_MEMRD;
            end else if (sts.led_hit) begin
              cmd.led_advance = 1'b1;
            end
          end
          MODE_ADC_OFF: cmd.adc_off = 1'b1;
          MODE_ADC_PER, MODE_BLINK: begin
            if (sts.period_zero) begin
              cmd.set_rej = 1'b1;
            end else begin
              cmd.div_start = 1'b1;
              state_nxt     = S_DIV;
            end
          end
          MODE_LED_OFF: cmd.led_off = 1'b1;
          MODE_MORSE: begin
            if (sts.length_zero) begin
              cmd.set_rej = 1'b1;
            end else begin
              cmd.morse_start = 1'b1;
            end
          end
          MODE_LOAD: cmd.tbl_write = 1'b1;
          default: ;
        endcase
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_ALIGN;
        end
      end
      S_ALIGN: begin
        cmd.align = 1'b1;
        state_nxt = S_FINISH;
      end
      S_MEMRD: begin
        cmd.tbl_read = 1'b1;
        state_nxt    = S_MUL;
      end
      S_MUL: begin
        cmd.morse_step = 1'b1;
        state_nxt      = S_LEDADV;
      end
      S_LEDADV: begin
        cmd.led_advance = 1'b1;
        state_nxt       = S_FINISH;
      end
      S_FINISH: begin
        // hold the result until the output register frees up
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == S_DECODE)
    else $error("accepted request did not enter decode");

  a_align_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ALIGN |-> $past(state_r == S_DIV) && $past(sts.div_last))
    else $error("alignment reached before divide finished");

endmodule

`default_nettype wire

// File: design/plas_dp.sv
// Datapath for the scheduler: tick counter, ADC and LED timers, restoring
// remainder unit, Morse table memory and result register. Uses plas_pkg.
`default_nettype none

module plas_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  plas_pkg::plas_in_t   in_data,
  input  logic                 cfg_wr,
  input  logic [15:0]          cfg_data,
  input  plas_pkg::plas_cmd_t  cmd,
  output plas_pkg::plas_sts_t  sts,
  output logic                 out_valid,
  input  logic                 out_stall,
  output plas_pkg::plas_out_t  out_data
);
  import plas_pkg::*;

  plas_in_t            req_r;
  logic [DIT_W-1:0]    dit_r;
  logic [TICK_W-1:0]   tick_r;
  logic [TICK_W-1:0]   adc_next_r;
  logic [PER_W-1:0]    adc_period_r;
  logic                adc_run_r;
  logic [TICK_W-1:0]   led_next_r;
  logic [PER_W-1:0]    led_period_r;
  logic                led_on_r;
  logic                led_run_r;
  logic                morse_run_r;
  logic [POS_W-1:0]    morse_pos_r;
  logic [POS_W-1:0]    morse_last_r;
  logic [PER_W-1:0]    rem_r;
  logic [TICK_IW-1:0]  div_cnt_r;
  logic [DITS_W-1:0]   tbl_dout_r;
  logic                tbl_oob_r;
  logic                changed_r;
  logic                fire_r;
  logic                rej_r;
  logic                out_valid_r;
  plas_out_t           out_data_r;

  logic [DITS_W-1:0]   tbl_mem [SEQ_DEPTH];

  logic [TICK_W-1:0]   tick_inc;
  logic                adc_hit;
  logic                led_hit;
  logic [PER_W:0]      div_part;
  logic                div_ge;
  logic [PER_W-1:0]    rem_nxt;
  logic [TICK_W-1:0]   align_nxt;
  logic [LEN_W-1:0]    sat_len;
  logic [DITS_W-1:0]   tbl_dits;
  logic [DITS_W+DIT_W-1:0] mul_prod;
  logic                pos_ok;
  logic                idx_ok;

  assign tick_inc = tick_r + 1'b1;
  assign adc_hit  = adc_run_r && (tick_inc >= adc_next_r);
  assign led_hit  = led_run_r && (tick_inc >= led_next_r);

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign div_part = {rem_r, tick_r[TICK_IW'(TICK_W-1) - div_cnt_r]};
  assign div_ge   = (div_part >= {1'b0, req_r.period});
  assign rem_nxt  = div_ge ? PER_W'(div_part - {1'b0, req_r.period}) : div_part[PER_W-1:0];

  // next period boundary above the counter, plus offset
  assign align_nxt = tick_r - TICK_W'(rem_r) + TICK_W'(req_r.period)
                   + TICK_W'(req_r.offset);

  assign sat_len = (req_r.morse_length > LEN_W'(SEQ_DEPTH)) ? LEN_W'(SEQ_DEPTH)
                                                           : req_r.morse_length;

  assign tbl_dits = tbl_oob_r ? '0 : tbl_dout_r;
  assign mul_prod = tbl_dits * dit_r;

  assign pos_ok = ({1'b0, morse_pos_r} < (POS_W+1)'(SEQ_DEPTH));
  assign idx_ok = ({1'b0, req_r.entry_index} < 9'(SEQ_DEPTH));

  assign sts.mode        = req_r.mode;
  assign sts.period_zero = (req_r.period == '0);
  assign sts.length_zero = (req_r.morse_length == '0);
  assign sts.led_hit     = led_hit;
  assign sts.morse_run   = morse_run_r;
  assign sts.div_last    = (div_cnt_r == TICK_IW'(TICK_W-1));
  assign sts.out_busy    = out_valid_r && out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // request capture and remainder unit carry no reset
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_data;
    end
    if (cmd.div_start) begin
      rem_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
    end
  end

  // Morse table
  always_ff @(posedge clk) begin
    if (cmd.tbl_write && idx_ok) begin
      tbl_mem[req_r.entry_index[SEQ_AW-1:0]] <= req_r.entry_dits;
    end
    if (cmd.tbl_read) begin
      tbl_dout_r <= tbl_mem[morse_pos_r[SEQ_AW-1:0]];
      tbl_oob_r  <= !pos_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!cmd.out_load || !(out_valid_r && out_stall)) begin
      if (cmd.out_load) begin
        out_data_r.led_level    <= led_on_r;
        out_data_r.led_changed  <= changed_r;
        out_data_r.adc_fire     <= fire_r;
        out_data_r.led_active   <= led_run_r;
        out_data_r.morse_active <= morse_run_r;
        out_data_r.rejected     <= rej_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dit_r        <= DIT_RESET;
      tick_r       <= '0;
      adc_next_r   <= '0;
      adc_period_r <= '0;
      adc_run_r    <= 1'b0;
      led_next_r   <= '0;
      led_period_r <= '0;
      led_on_r     <= 1'b0;
      led_run_r    <= 1'b0;
      morse_run_r  <= 1'b0;
      morse_pos_r  <= '0;
      morse_last_r <= '0;
      div_cnt_r    <= '0;
      changed_r    <= 1'b0;
      fire_r       <= 1'b0;
      rej_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        dit_r <= cfg_data;
      end

      if (cmd.capture) begin
        changed_r <= 1'b0;
        fire_r    <= 1'b0;
        rej_r     <= 1'b0;
      end

      if (cmd.tick_step) begin
        tick_r <= tick_inc;
        if (adc_hit) begin
          adc_next_r <= adc_next_r + TICK_W'(adc_period_r);
          fire_r     <= 1'b1;
        end
      end

      if (cmd.led_advance) begin
        led_next_r <= led_next_r + TICK_W'(led_period_r);
        led_on_r   <= !led_on_r;
        changed_r  <= 1'b1;
      end

      if (cmd.adc_off) begin
        adc_run_r <= 1'b0;
      end

      if (cmd.led_off) begin
        led_run_r   <= 1'b0;
        morse_run_r <= 1'b0;
        led_on_r    <= req_r.off_level;
        changed_r   <= 1'b1;
      end

      if (cmd.set_rej) begin
        rej_r <= 1'b1;
      end

      if (cmd.morse_start) begin
        morse_pos_r  <= '0;
        morse_last_r <= POS_W'(sat_len - 1'b1);
        led_on_r     <= 1'b0;
        led_next_r   <= tick_r;
        led_run_r    <= 1'b1;
        morse_run_r  <= 1'b1;
        changed_r    <= 1'b1;
      end

      if (cmd.div_start) begin
        div_cnt_r <= '0;
      end else if (cmd.div_step) begin
        div_cnt_r <= div_cnt_r + 1'b1;
      end

      if (cmd.align) begin
        if (req_r.mode == MODE_ADC_PER) begin
          adc_period_r <= req_r.period;
          adc_next_r   <= align_nxt;
          adc_run_r    <= 1'b1;
        end else begin
          led_period_r <= req_r.period;
          led_next_r   <= align_nxt;
          led_on_r     <= 1'b0;
          led_run_r    <= 1'b1;
          changed_r    <= 1'b1;
        end
      end

      // take the next table entry; stop after the last one
      if (cmd.morse_step) begin
        led_period_r <= mul_prod[PER_W-1:0];
        morse_pos_r  <= morse_pos_r + 1'b1;
        if (morse_pos_r == morse_last_r) begin
          morse_run_r <= 1'b0;
          led_run_r   <= 1'b0;
        end
      end

      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_tick_by_one: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$stable(tick_r) |-> tick_r == $past(tick_r) + 1'b1)
    else $error("tick counter moved by other than one");

  a_fire_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load && fire_r |-> req_r.mode == MODE_TICK)
    else $error("ADC fire reported for a command request");

  a_morse_needs_led: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !out_data_r.morse_active || out_data_r.led_active)
    else $error("Morse playback shown without LED activity");

endmodule

`default_nettype wire

// File: design/periodic_led_adc_scheduler.sv
// Top level of the periodic LED / ADC scheduler: joins plas_ctrl and plas_dp.
// Depends on plas_pkg, plas_ctrl and plas_dp.
//
//   channel  | handshake            | payload
//   ---------+----------------------+----------------------------------
//   in_      | in_valid / in_stall  | in_data   (plas_in_t, one request)
//   out_     | out_valid / out_stall| out_data  (plas_out_t, one result)
//   cfg_     | cfg_valid / cfg_ready| cfg_data  (dit duration, 16 bits)
//
// A plain tick or command passes from accept through decode and finish; a tick that
// toggles the LED in Morse mode also goes through table read, 8x16 multiply and LED update.
// Adc periodic and blink also run the 32-step restoring remainder unit, then align.
// Synchronous active-low reset; the Morse table is not cleared and holds no valid bits.
// in_stall is high while a request is at work; a finished result waits in the output
// register, and the next request is taken while out_stall holds it.
`default_nettype none

module periodic_led_adc_scheduler (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  plas_pkg::plas_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output plas_pkg::plas_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);
  import plas_pkg::*;

  plas_cmd_t cmd;
  plas_sts_t sts;
  logic      cfg_wr;

  // configuration writes must land only while idle; the user ensures it, not the block, so always take them
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  plas_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  plas_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_wr    (cfg_wr),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
